// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Request and status codes, cell operations and the control result bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Default number of list slots.
  localparam int unsigned DefCapacity = 16;

  // Field widths fixed by the interface.
  localparam int unsigned ReqW = 3;
  localparam int unsigned PosW = 5;
  localparam int unsigned ValW = 32;
  localparam int unsigned LenW = 5;

  // Request codes.
  typedef enum logic [ReqW-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_REM_FRONT = 3'd3,
    REQ_REM_BACK  = 3'd4,
    REQ_REM_POS   = 3'd5,
    REQ_CLEAR     = 3'd6
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // What one cell does with its word in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LEFT  = 2'd2,
    OP_FROM_RIGHT = 2'd3
  } cell_op_e;

  // Outcome of one request as seen by the output stage.
  typedef struct packed {
    status_e status;
    logic    take;
  } res_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one slot of the list
// Holds one word and, per cycle, keeps it, loads the new word, or takes the
// word of its left or right neighbor.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                               clk_i,
  input  ple_pkg::cell_op_e                  op_i,
  input  logic signed [ple_pkg::ValW-1:0]    load_i,
  input  logic signed [ple_pkg::ValW-1:0]    left_i,
  input  logic signed [ple_pkg::ValW-1:0]    right_i,
  output logic signed [ple_pkg::ValW-1:0]    data_o
);

  logic signed [ple_pkg::ValW-1:0] data_d;
  logic signed [ple_pkg::ValW-1:0] data_q;

  // Select the next word from the requested source.
  always_comb begin
    case (op_i)
      ple_pkg::OP_LOAD:       data_d = load_i;
      ple_pkg::OP_FROM_LEFT:  data_d = left_i;
      ple_pkg::OP_FROM_RIGHT: data_d = right_i;
      default:                data_d = data_q;
    endcase
  end

  // Slot contents are payload and need no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl: request decode for the list
// Checks bounds against the element count, picks the target slot and tells
// every cell whether to hold, load or shift.
// ----------------------------------------------------------------------------
module ple_ctrl #(
  parameter int unsigned Capacity = ple_pkg::DefCapacity,
  localparam int unsigned CntW = $clog2(Capacity + 1),
  localparam int unsigned IdxW = $clog2(Capacity)
) (
  input  logic                        en_i,
  input  logic [ple_pkg::ReqW-1:0]    req_type_i,
  input  logic [ple_pkg::PosW-1:0]    position_i,
  input  logic [CntW-1:0]             count_i,
  output logic [CntW-1:0]             count_d_o,
  output logic [IdxW-1:0]             idx_o,
  output ple_pkg::res_t               res_o,
  output ple_pkg::cell_op_e           op_o [Capacity]
);

  // Compare width wide enough for both the position and the count plus one.
  localparam int unsigned KW = ((CntW > ple_pkg::PosW) ? CntW : ple_pkg::PosW) + 1;

  logic [KW-1:0] pos_w;
  logic [KW-1:0] cnt_w;
  logic [KW-1:0] k_w;
  logic          full;
  logic          empty;
  logic          do_ins;
  logic          do_rem;

  assign pos_w = KW'(position_i);
  assign cnt_w = KW'(count_i);
  assign full  = (count_i == CntW'(Capacity));
  assign empty = (count_i == '0);

  // Decode the request into an insert or remove at slot k, or a status.
  always_comb begin
    k_w          = '0;
    do_ins       = 1'b0;
    do_rem       = 1'b0;
    count_d_o    = count_i;
    res_o.status = ple_pkg::ST_OK;
    case (ple_pkg::req_e'(req_type_i))
      ple_pkg::REQ_INS_FRONT: begin
        if (full) res_o.status = ple_pkg::ST_FULL;
        else      do_ins = 1'b1;
      end
      ple_pkg::REQ_INS_BACK: begin
        k_w = cnt_w;
        if (full) res_o.status = ple_pkg::ST_FULL;
        else      do_ins = 1'b1;
      end
      ple_pkg::REQ_INS_POS: begin
        k_w = pos_w - KW'(1);
        if (pos_w == '0 || pos_w > cnt_w + KW'(1)) res_o.status = ple_pkg::ST_BADPOS;
        else if (full)                             res_o.status = ple_pkg::ST_FULL;
        else                                       do_ins = 1'b1;
      end
      ple_pkg::REQ_REM_FRONT: begin
        if (empty) res_o.status = ple_pkg::ST_EMPTY;
        else       do_rem = 1'b1;
      end
      ple_pkg::REQ_REM_BACK: begin
        k_w = cnt_w - KW'(1);
        if (empty) res_o.status = ple_pkg::ST_EMPTY;
        else       do_rem = 1'b1;
      end
      ple_pkg::REQ_REM_POS: begin
        k_w = pos_w - KW'(1);
        if (empty)                              res_o.status = ple_pkg::ST_EMPTY;
        else if (pos_w == '0 || pos_w > cnt_w)  res_o.status = ple_pkg::ST_BADPOS;
        else                                    do_rem = 1'b1;
      end
      ple_pkg::REQ_CLEAR: begin
        count_d_o = '0;
      end
      default: begin
      end
    endcase
    if (do_ins) count_d_o = count_i + CntW'(1);
    if (do_rem) count_d_o = count_i - CntW'(1);
    res_o.take = do_rem;
  end

  assign idx_o = k_w[IdxW-1:0];

  // Per-cell operation: cells above k shift up on insert, cells from k shift
  // down on remove. Slots beyond the count carry no meaning.
  for (genvar i = 0; i < Capacity; i++) begin : g_op
    always_comb begin
      op_o[i] = ple_pkg::OP_HOLD;
      if (en_i && do_ins) begin
        if (k_w == KW'(i))     op_o[i] = ple_pkg::OP_LOAD;
        else if (k_w < KW'(i)) op_o[i] = ple_pkg::OP_FROM_LEFT;
      end else if (en_i && do_rem && i < Capacity - 1) begin
        if (k_w <= KW'(i)) op_o[i] = ple_pkg::OP_FROM_RIGHT;
      end
    end
  end

endmodule

// ===== rtl/core/positional_list_engine_unit.sv =====
// A result word is valid in the cycle after its request word is accepted.
// The block takes one request per cycle while its output is drained; every slot
// cell updates in parallel from the decoded target slot and the element count,
// and the output register frees in the cycle its word is taken.
// Reset clears the element count and the output valid; slot contents are
// left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// positional_list_engine_unit: bounded ordered list with positional access
// A row of slot cells with a shared request decoder and one output register.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int unsigned Capacity = ple_pkg::DefCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ple_pkg::ReqW-1:0]         req_type_i,
  input  logic [ple_pkg::PosW-1:0]         position_i,
  input  logic signed [ple_pkg::ValW-1:0]  value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [ple_pkg::ValW-1:0]  removed_value_o,
  output logic [1:0]                       status_o,
  output logic [ple_pkg::LenW-1:0]         length_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = $clog2(Capacity);

  logic                            fire;
  logic [CntW-1:0]                 count_d;
  logic [CntW-1:0]                 count_q;
  logic [IdxW-1:0]                 idx;
  ple_pkg::res_t                   res;
  ple_pkg::cell_op_e               op [Capacity];
  logic signed [ple_pkg::ValW-1:0] slot [Capacity];
  logic signed [ple_pkg::ValW-1:0] rd_word;
  logic                            out_valid_q;
  logic signed [ple_pkg::ValW-1:0] removed_q;
  logic [1:0]                      status_q;
  logic [ple_pkg::LenW-1:0]        length_q;

  // A new word enters whenever the output register is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Request decode and per-cell control.
  ple_ctrl #(
    .Capacity(Capacity)
  ) u_ctrl (
    .en_i      (fire),
    .req_type_i(req_type_i),
    .position_i(position_i),
    .count_i   (count_q),
    .count_d_o (count_d),
    .idx_o     (idx),
    .res_o     (res),
    .op_o      (op)
  );

  // Row of slot cells, each linked to its neighbors.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [ple_pkg::ValW-1:0] left_w;
    logic signed [ple_pkg::ValW-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_inner_l
      assign left_w = slot[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_w = slot[i];
    end else begin : g_inner_r
      assign right_w = slot[i+1];
    end
    ple_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op[i]),
      .load_i (value_i),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (slot[i])
    );
  end

  // Pick the word at the target slot with an AND-OR select.
  always_comb begin
    rd_word = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (idx == IdxW'(i)) rd_word = rd_word | slot[i];
    end
  end

  // Element count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      removed_q <= res.take ? rd_word : '0;
      status_q  <= res.status;
      length_q  <= ple_pkg::LenW'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign length_o        = length_q;

`ifndef NO_ASSERTIONS
  // A full status is only reported with the list at capacity.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ple_pkg::ST_FULL |-> length_o == ple_pkg::LenW'(Capacity))
    else $error("full status with list not at capacity");

  // An empty status comes with an empty list and no removed word.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ple_pkg::ST_EMPTY |-> length_o == '0 && removed_value_o == '0)
    else $error("empty status with elements or a removed word");

  // The element count never exceeds the capacity.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("element count above capacity");

  // The element count moves only when a request word is accepted.
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("element count changed without a request");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the positional list engine
// Drives request words with random gaps, keeps its own list model to predict
// each result word, and checks every result field against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LIST_CAP    = ple_pkg::DefCapacity;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_IDLE    = 16;

  // The one request code that the block leaves unused.
  localparam logic [ple_pkg::ReqW-1:0] REQ_UNUSED = 3'd7;

  // One predicted result word.
  typedef struct packed {
    logic signed [ple_pkg::ValW-1:0] removed;
    ple_pkg::status_e                status;
    logic [ple_pkg::LenW-1:0]        length;
  } list_result_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic [ple_pkg::ReqW-1:0]        req_type_i  = '0;
  logic [ple_pkg::PosW-1:0]        position_i  = '0;
  logic signed [ple_pkg::ValW-1:0] value_i     = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic signed [ple_pkg::ValW-1:0] removed_value_o;
  logic [1:0]                      status_o;
  logic [ple_pkg::LenW-1:0]        length_o;

  // Shadow copy of the list held by the block.
  logic signed [ple_pkg::ValW-1:0] list_slots [LIST_CAP];
  int unsigned                     list_len = 0;

  list_result_t expected_results [$];
  int unsigned  error_count = 0;

  // Idling switches for each side and the request for a long receiver hold.
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_out  = 1'b0;

  positional_list_engine_unit #(
    .Capacity(LIST_CAP)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .length_o       (length_o)
  );

  always #10 clk_i = ~clk_i;

  // Insert a value so that it becomes element idx, shifting later ones up.
  function automatic ple_pkg::status_e slide_in(int unsigned idx,
                                                logic signed [ple_pkg::ValW-1:0] val);
    int unsigned i;
    if (list_len >= LIST_CAP) return ple_pkg::ST_FULL;
    for (i = list_len; i > idx; i--) list_slots[i] = list_slots[i-1];
    list_slots[idx] = val;
    list_len++;
    return ple_pkg::ST_OK;
  endfunction

  // Take element idx out, shifting later ones down; idx is below list_len.
  function automatic logic signed [ple_pkg::ValW-1:0] slide_out(int unsigned idx);
    int unsigned                     i;
    logic signed [ple_pkg::ValW-1:0] val;
    val = list_slots[idx];
    for (i = idx; i + 1 < list_len; i++) list_slots[i] = list_slots[i+1];
    list_len--;
    return val;
  endfunction

  // Apply one request word to the shadow list and return its result word.
  function automatic list_result_t apply_request(logic [ple_pkg::ReqW-1:0] req,
                                                 logic [ple_pkg::PosW-1:0] pos,
                                                 logic signed [ple_pkg::ValW-1:0] val);
    list_result_t res;
    res.removed = '0;
    res.status  = ple_pkg::ST_OK;
    case (req)
      ple_pkg::REQ_INS_FRONT: res.status = slide_in(0, val);
      ple_pkg::REQ_INS_BACK:  res.status = slide_in(list_len, val);
      ple_pkg::REQ_INS_POS: begin
        if (pos == 0 || pos > list_len + 1) res.status = ple_pkg::ST_BADPOS;
        else res.status = slide_in(pos - 1, val);
      end
      ple_pkg::REQ_REM_FRONT: begin
        if (list_len == 0) res.status = ple_pkg::ST_EMPTY;
        else res.removed = slide_out(0);
      end
      ple_pkg::REQ_REM_BACK: begin
        if (list_len == 0) res.status = ple_pkg::ST_EMPTY;
        else res.removed = slide_out(list_len - 1);
      end
      ple_pkg::REQ_REM_POS: begin
        if (list_len == 0) res.status = ple_pkg::ST_EMPTY;
        else if (pos == 0 || pos > list_len) res.status = ple_pkg::ST_BADPOS;
        else res.removed = slide_out(pos - 1);
      end
      ple_pkg::REQ_CLEAR: list_len = 0;
      default: ;
    endcase
    res.length = list_len[ple_pkg::LenW-1:0];
    return res;
  endfunction

  // Mostly random values, with the extremes mixed in now and then.
  function automatic logic signed [ple_pkg::ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request word and record its predicted result once accepted.
  task automatic send_word(input logic [ple_pkg::ReqW-1:0] req,
                           input logic [ple_pkg::PosW-1:0] pos,
                           input logic signed [ple_pkg::ValW-1:0] val);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(apply_request(req, pos, val));
  endtask

  // Stop offering words until every predicted result word has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Front and positional removal, two bad insert positions and the unused code on an empty list.
  task automatic test_empty_list();
    send_word(ple_pkg::REQ_REM_FRONT, 5'd0, 32'sd5);
    send_word(ple_pkg::REQ_REM_POS, 5'd31, '1);
    send_word(ple_pkg::REQ_INS_POS, 5'd0, 32'sh7FFF_FFFF);
    send_word(ple_pkg::REQ_INS_POS, 5'd2, 32'sh8000_0000);
    send_word(REQ_UNUSED, 5'd31, '1);
  endtask

  // Fill the list to capacity, hit the full and bad-position cases, then empty it.
  task automatic test_fill_to_capacity();
    logic signed [ple_pkg::ValW-1:0] patterns [8];
    int unsigned                     i;
    patterns = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                 32'shAAAA_AAAA, 32'sh5555_5555, 32'sd1, 32'sh0F0F_F0F0};
    for (i = 0; i < LIST_CAP; i++) begin
      case (i % 3)
        0: send_word(ple_pkg::REQ_INS_FRONT, '0, patterns[i % 8] ^ i);
        1: send_word(ple_pkg::REQ_INS_BACK, '0, patterns[i % 8] ^ i);
        default: send_word(ple_pkg::REQ_INS_POS, ple_pkg::PosW'(i / 2 + 1),
                           patterns[i % 8] ^ i);
      endcase
    end
    send_word(ple_pkg::REQ_INS_BACK, '0, 32'sd77);
    // A position just past the end is legal, so the list being full wins.
    send_word(ple_pkg::REQ_INS_POS, 5'd17, 32'sd78);
    send_word(ple_pkg::REQ_INS_POS, 5'd18, 32'sd79);
    send_word(ple_pkg::REQ_REM_POS, 5'd0, '0);
    send_word(ple_pkg::REQ_REM_POS, 5'd17, '0);
    send_word(ple_pkg::REQ_REM_POS, 5'd16, '0);
    send_word(ple_pkg::REQ_REM_FRONT, '0, '0);
    send_word(ple_pkg::REQ_REM_BACK, '0, '0);
    send_word(ple_pkg::REQ_CLEAR, 5'd9, '1);
    send_word(ple_pkg::REQ_REM_BACK, '0, '0);
  endtask

  // Mostly well-formed requests whose mix drifts between growing and shrinking.
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned              k;
    int unsigned              lean;
    int unsigned              roll;
    bit                       grow;
    logic [ple_pkg::ReqW-1:0] req;
    logic [ple_pkg::PosW-1:0] pos;
    lean = 2;
    for (k = 0; k < n_words; k++) begin
      if (k % 40 == 0) begin
        lean      = $urandom_range(0, 2);
        send_idle = $urandom_range(0, 1);
        recv_idle = $urandom_range(0, 1);
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        req = ple_pkg::ReqW'($urandom_range(0, 7));
        pos = ple_pkg::PosW'($urandom_range(0, 31));
      end else if (roll == 99) begin
        req = ple_pkg::REQ_CLEAR;
        pos = ple_pkg::PosW'($urandom_range(0, 31));
      end else begin
        case (lean)
          0: grow = ($urandom_range(0, 99) < 75);
          1: grow = ($urandom_range(0, 99) < 25);
          default: grow = $urandom_range(0, 1);
        endcase
        if (grow) begin
          pos = ple_pkg::PosW'($urandom_range(1, list_len + 1));
          case ($urandom_range(0, 2))
            0: req = ple_pkg::REQ_INS_FRONT;
            1: req = ple_pkg::REQ_INS_BACK;
            default: req = ple_pkg::REQ_INS_POS;
          endcase
        end else begin
          pos = (list_len == 0) ? ple_pkg::PosW'($urandom_range(0, 31))
                                : ple_pkg::PosW'($urandom_range(1, list_len));
          case ($urandom_range(0, 2))
            0: req = ple_pkg::REQ_REM_FRONT;
            1: req = ple_pkg::REQ_REM_BACK;
            default: req = ple_pkg::REQ_REM_POS;
          endcase
        end
      end
      send_word(req, pos, pick_value());
    end
  endtask

  // Hold the receiver off while words keep coming, then let it all drain.
  task automatic test_backpressure();
    int unsigned k;
    send_idle = 1'b0;
    hold_out  = 1'b1;
    for (k = 0; k < 40; k++) begin
      send_word((k % 2 == 0) ? ple_pkg::REQ_INS_BACK : ple_pkg::REQ_REM_FRONT, '0,
                pick_value());
    end
    wait_for_results();
  endtask

  // Receiver: random stall before each result word, or one long hold on request.
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_out = 1'b0;
      end else begin
        stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  initial begin : result_checker
    list_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected: removed %0d status %0d length %0d",
                   $time, removed_value_o, status_o, length_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (removed_value_o !== want.removed) begin
            $display("%0t: removed_value expected %0d, got %0d",
                     $time, want.removed, removed_value_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
            error_count++;
          end
          if (length_o !== want.length) begin
            $display("%0t: length expected %0d, got %0d", $time, want.length, length_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // Test sequence.
  initial begin : main_sequence
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_fill_to_capacity();
    test_random_traffic(600);
    test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random_traffic(400);
    wait_for_results();
    test_random_traffic(700);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
